// ===== sv/btda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package btda_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned COUNT_W = 4;

	localparam logic [1:0] MODE_SIGNED = 2'd0;
	localparam logic [1:0] MODE_UNSIGNED = 2'd1;
	localparam logic [1:0] MODE_FIXED = 2'd2;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_OVER = 8'h76;

	// ceil(2^35 / 10): floor(x * RECIP_10 >> 35) == x / 10 for any 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         mode;
		logic [3:0]         field_width;
	} req_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic step_last;
		logic emit_last;
	} dp_status_t;

endpackage

// ===== sv/binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit word to decimal ASCII text, one character per output beat.
// ----------------------------------------------------------------------------
// A number is taken when idle, then ten divide-by-ten steps (one shared
// 32x32 reciprocal multiplier, one step per cycle) peel off its digits, and
// the characters leave one per cycle while the output is not stalled, the
// final one flagged by last. A number gives 1 to 11 characters. The next
// number is accepted as soon as the last character sits in the output
// register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  btda_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output btda_pkg::rsp_t   rsp
);

	btda_pkg::dp_cmd_t    cmd;
	btda_pkg::dp_status_t status;

	btda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.status    (status)
	);

	btda_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

// ===== sv/btda_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_datapath
// Magnitude, divide-by-ten digit extraction, digit store and output register.
// ----------------------------------------------------------------------------
module btda_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btda_pkg::req_t       req,
	input  btda_pkg::dp_cmd_t    cmd,
	output btda_pkg::dp_status_t status,
	output btda_pkg::rsp_t       rsp
);

	localparam int unsigned VW = btda_pkg::VALUE_W;
	localparam int unsigned DW = btda_pkg::DIGIT_W;
	localparam int unsigned CW = btda_pkg::COUNT_W;
	localparam int unsigned QW = 2 * VW - btda_pkg::RECIP_SHIFT;
	localparam logic [CW-1:0] LAST_STEP = CW'(btda_pkg::MAX_DIGITS - 1);
	localparam logic [CW-1:0] MAXD = CW'(btda_pkg::MAX_DIGITS);

	logic [VW-1:0]  cur_q;
	logic [CW-1:0]  step_q;
	logic [CW-1:0]  ndig_q;
	logic           found_q;
	logic           fixed_q;
	logic           neg_q;
	logic [CW-1:0]  width_q;
	logic           pre_pending_q;
	logic [CW-1:0]  rem_q;
	logic [DW-1:0]  digits_q [btda_pkg::MAX_DIGITS];
	btda_pkg::rsp_t rsp_q;

	logic           neg_in;
	logic [VW-1:0]  mag_in;
	logic [CW-1:0]  width_in;
	logic [2*VW-1:0] prod;
	logic [QW-1:0]  quot;
	logic [VW-1:0]  quot_x10;
	logic [VW-1:0]  rem_full;
	logic [DW-1:0]  digit;
	logic [CW-1:0]  ndig_next;
	logic           over;
	logic [7:0]     char_cur;
	logic           last_cur;

	always_comb begin
		neg_in = (req.mode == btda_pkg::MODE_SIGNED) && req.value[VW-1];
		mag_in = neg_in ? (~req.value + VW'(1)) : req.value;
		if (req.field_width == '0) begin
			width_in = CW'(1);
		end else if (req.field_width > MAXD) begin
			width_in = MAXD;
		end else begin
			width_in = req.field_width;
		end
	end

	// one divide-by-ten step: multiply by the reciprocal, remainder by shift-add
	always_comb begin
		prod     = {{VW{1'b0}}, cur_q} * {{VW{1'b0}}, btda_pkg::RECIP_10};
		quot     = prod[2*VW-1:btda_pkg::RECIP_SHIFT];
		quot_x10 = (VW'(quot) << 3) + (VW'(quot) << 1);
		rem_full = cur_q - quot_x10;
		digit    = rem_full[DW-1:0];
		if (!found_q && quot == '0) begin
			ndig_next = step_q + CW'(1);
		end else begin
			ndig_next = ndig_q;
		end
		over = ndig_next > width_q;
	end

	always_comb begin
		if (pre_pending_q) begin
			char_cur = fixed_q ? btda_pkg::CHAR_OVER : btda_pkg::CHAR_MINUS;
			last_cur = (rem_q == '0);
		end else begin
			char_cur = btda_pkg::CHAR_ZERO + 8'(digits_q[rem_q - CW'(1)]);
			last_cur = (rem_q == CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= mag_in;
			step_q  <= '0;
			found_q <= 1'b0;
			ndig_q  <= CW'(1);
			fixed_q <= (req.mode == btda_pkg::MODE_FIXED);
			neg_q   <= neg_in;
			width_q <= width_in;
		end else if (cmd.step) begin
			digits_q[step_q] <= digit;
			cur_q            <= VW'(quot);
			step_q           <= step_q + CW'(1);
			ndig_q           <= ndig_next;
			if (quot == '0) begin
				found_q <= 1'b1;
			end
			if (step_q == LAST_STEP) begin
				if (fixed_q) begin
					pre_pending_q <= over;
					rem_q         <= over ? (width_q - CW'(1)) : width_q;
				end else begin
					pre_pending_q <= neg_q;
					rem_q         <= ndig_next;
				end
			end
		end else if (cmd.emit) begin
			rsp_q.character <= char_cur;
			rsp_q.last      <= last_cur;
			if (pre_pending_q) begin
				pre_pending_q <= 1'b0;
			end else begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	assign status.step_last = (step_q == LAST_STEP);
	assign status.emit_last = last_cur;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	// reciprocal must give an exact decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (rem_full < VW'(10)))
		else $error("divide step remainder out of range");

	// ten steps always exhaust a 32-bit magnitude
	a_conv_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.step_last) |=> (cur_q == '0) && found_q)
		else $error("magnitude not exhausted after final step");

	// a beat to emit always exists when emitting
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (pre_pending_q || rem_q != '0))
		else $error("emit with nothing left");
`endif

endmodule

// ===== sv/btda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_ctrl
// Sequencer: accept, ten divide steps, then one beat per character.
// ----------------------------------------------------------------------------
module btda_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output btda_pkg::dp_cmd_t    cmd,
	input  btda_pkg::dp_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && req_valid;
		cmd.step   = (state_q == ST_CONV);
		cmd.emit   = (state_q == ST_EMIT) && slot_free;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_next = ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.step_last) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free && status.emit_last) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef NO_ASSERTIONS
	// a pending beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !cmd.emit)
		else $error("output beat overwritten");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_CONV))
		else $error("accepted item did not start conversion");

	a_conv_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && status.step_last) |=> (state_q == ST_EMIT))
		else $error("conversion did not hand over to emission");

	// the final beat of a number is the one that returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.emit_last) |=> (state_q == ST_IDLE) && rsp_valid_q)
		else $error("final beat did not end the burst");
`endif

endmodule
